>>> rtl/tss_pkg.sv
package tss_pkg;

  // Fixed field widths of the item
  localparam int VALUE_W  = 32;
  localparam int SID_W    = 2;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } tss_state_t;

endpackage

>>> rtl/tss_ram.sv
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tss_core.sv
module tss_core #(
  parameter int POOL_DEPTH = 16,
  parameter int NUM_STACKS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [tss_pkg::SID_W-1:0]     in_sid,
  input  logic [tss_pkg::VALUE_W-1:0]   in_value,
  input  logic                          out_free,
  output logic                          res_valid,
  output logic [tss_pkg::VALUE_W-1:0]   res_value,
  output tss_pkg::status_t              res_status
);
  import tss_pkg::*;

  localparam int PTR_W = $clog2(POOL_DEPTH + 1);
  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int SEL_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

  tss_state_t state, state_next;

  logic [PTR_W-1:0]   tops [NUM_STACKS];
  logic [PTR_W-1:0]   free_head;
  logic [PTR_W-1:0]   fresh_count;

  // Latched item
  logic               op_func;
  logic               op_sid_ok;
  logic [SEL_W-1:0]   op_sel;
  logic [VALUE_W-1:0] op_value;
  logic [PTR_W-1:0]   op_top;
  logic [PTR_W-1:0]   rd_ptr;

  logic               accept, commit;
  logic               in_sid_ok;
  logic [SEL_W-1:0]   in_sel;
  logic [PTR_W-1:0]   in_top, in_rd_ptr;
  logic [IDX_W-1:0]   raddr;

  logic               pop_ok, push_ok, use_free, use_fresh, is_pop;
  logic [PTR_W-1:0]   entry;

  logic               val_we, link_we;
  logic [IDX_W-1:0]   val_waddr, link_waddr;
  logic [PTR_W-1:0]   link_wdata, link_rdata;
  logic [VALUE_W-1:0] val_rdata;

  assign accept    = in_valid && in_ready;
  assign in_sid_ok = 32'(in_sid) < NUM_STACKS;
  assign in_sel    = SEL_W'(in_sid);
  assign in_top    = in_sid_ok ? tops[in_sel] : NULL_PTR;
  // pop reads the top entry, push reads the free-list head's link
  assign in_rd_ptr = (in_func == FUNC_POP) ? in_top : free_head;
  assign raddr     = (state == S_IDLE) ? in_rd_ptr[IDX_W-1:0] : rd_ptr[IDX_W-1:0];

  tss_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (op_value),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  tss_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  // Execute-cycle decisions
  assign is_pop    = (op_func == FUNC_POP);
  assign pop_ok    = op_sid_ok && (op_top != NULL_PTR);
  assign use_free  = (free_head != NULL_PTR);
  assign use_fresh = !use_free && (fresh_count < NULL_PTR);
  assign push_ok   = op_sid_ok && (use_free || use_fresh);
  assign entry     = use_free ? free_head : fresh_count;

  assign val_we     = commit && !is_pop && push_ok;
  assign val_waddr  = entry[IDX_W-1:0];
  assign link_we    = commit && (is_pop ? pop_ok : push_ok);
  assign link_waddr = is_pop ? op_top[IDX_W-1:0] : entry[IDX_W-1:0];
  assign link_wdata = is_pop ? free_head : op_top;

  always_comb begin
    res_value  = '0;
    res_status = ST_OK;
    if (is_pop) begin
      if (pop_ok) begin
        res_value = val_rdata;
      end else begin
        res_status = ST_EMPTY;
      end
    end else if (!push_ok) begin
      res_status = ST_FULL;
    end
  end

  // FSM: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_EXEC:  commit   = out_free;
      default: ;
    endcase
  end

  assign res_valid = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= NULL_PTR;
      fresh_count <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops[i] <= NULL_PTR;
      end
    end else begin
      state <= state_next;
      if (commit) begin
        if (is_pop) begin
          if (pop_ok) begin
            tops[op_sel] <= link_rdata;
            free_head    <= op_top;
          end
        end else if (push_ok) begin
          tops[op_sel] <= entry;
          if (use_free) begin
            free_head <= link_rdata;
          end else begin
            fresh_count <= fresh_count + PTR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func   <= in_func;
      op_sid_ok <= in_sid_ok;
      op_sel    <= in_sel;
      op_value  <= in_value;
      op_top    <= in_top;
      rd_ptr    <= in_rd_ptr;
    end
  end

endmodule

>>> rtl/three_stacks_shared_pool.sv
// Three LIFO stacks sharing one pool of POOL_DEPTH entries.
// Input channel s_*: one item per operation. s_tuser carries the opcode
// (push or pop) and the stack id, s_tdata the value to push.
// Output channel m_*: exactly one result item per input item, in order.
// m_tdata is the popped value (zero for pushes and failed pops), m_tuser
// the status: ok, pop from empty stack, or push into a full pool.
// Unknown stack ids fail like an empty pop or a full push.
// Timing: an item is taken in the idle state and its result is registered
// when the execute state ends, which it does once the output register
// frees up. The execute state is set by the registered read of the value
// and link RAMs, read in the accept cycle and written back in the execute
// cycle. The block takes no new item until its result is registered.
// The block holds one item at a time; it accepts the next item while the
// previous result still sits in the output register.
// A stall on m_tready holds the execute cycle (and so s_tready low) until
// the output register frees up; nothing is lost or reordered.
// Reset (rst, synchronous) empties all stacks and the free list and drops
// m_tvalid. RAM contents are not cleared: entries are only read after a
// push has written them, so no clearing pass is needed.
module three_stacks_shared_pool #(
  parameter int POOL_DEPTH = 16,
  parameter int NUM_STACKS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tss_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] push_value
  input  logic [tss_pkg::SID_W:0]       s_tuser,  // [0] func, [2:1] stack_id
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tss_pkg::VALUE_W-1:0]   m_tdata,  // [31:0] pop_value
  output logic [tss_pkg::STATUS_W-1:0]  m_tuser   // [1:0] status
);
  import tss_pkg::*;

  logic               out_free;
  logic               res_valid;
  logic [VALUE_W-1:0] res_value;
  status_t            res_status;

  // Output register frees when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  tss_core #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_STACKS (NUM_STACKS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tuser[0]),
    .in_sid     (s_tuser[SID_W:1]),
    .in_value   (s_tdata),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

endmodule

>>> rtl/tss_checker.sv
module tss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tss_pkg::VALUE_W-1:0]   m_tdata,
  input logic [tss_pkg::STATUS_W-1:0]  m_tuser
);
  import tss_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL))
    else $error("undefined status");

  // A failed operation returns no value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("failed op carries data");

  // One item in flight: no accept in the cycle after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  // No result straight out of reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind three_stacks_shared_pool tss_checker u_tss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> verif/three_stacks_shared_pool_tb.sv
`timescale 1ns / 1ps

module three_stacks_shared_pool_tb;
  import tss_pkg::*;

  localparam int POOL_DEPTH = 16;
  localparam int NUM_STACKS = 3;
  // Pointer value that marks an empty stack or an empty free list
  localparam logic [4:0] NIL_SLOT = 5'(POOL_DEPTH);
  localparam logic [1:0] BAD_SID = 2'd3;  // beyond the last stack

  // One stack operation as the sender presents it
  typedef struct {
    logic             op;
    logic [1:0]       sid;
    logic [31:0]      value;
  } stack_op_t;

  // One result item as the block should return it
  typedef struct {
    logic [31:0]      pop_value;
    status_t          status;
  } stack_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [VALUE_W-1:0]   s_tdata = '0;   // [31:0] push_value
  logic [SID_W:0]       s_tuser = '0;   // [0] func, [2:1] stack_id
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [VALUE_W-1:0]   m_tdata;        // [31:0] pop_value
  logic [STATUS_W-1:0]  m_tuser;        // [1:0] status

  three_stacks_shared_pool #(
    .POOL_DEPTH(POOL_DEPTH),
    .NUM_STACKS(NUM_STACKS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Operations waiting for the driver, and results waiting for the monitor
  stack_op_t     op_queue[$];
  stack_result_t expected_results[$];

  int ops_queued   = 0;
  int ops_accepted = 0;
  int fail_count   = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int recv_idle_pct = 0;   // chance per cycle that the receiver stalls
  bit item_taken    = 1'b0; // input handshake seen at the last rising edge

  // Shadow copy of the pool: values, links, stack tops, free list, fresh counter
  logic [31:0] pool_value [POOL_DEPTH];
  logic [4:0]  pool_link  [POOL_DEPTH];
  logic [4:0]  top_slot   [NUM_STACKS];
  logic [4:0]  free_head  = NIL_SLOT;
  logic [4:0]  fresh_count = '0;

  initial begin
    for (int i = 0; i < NUM_STACKS; i++) top_slot[i] = NIL_SLOT;
  end

  // Applies one operation to the shadow pool and returns what the block should answer.
  // Bad stack ids fail like an empty pop or a full push and leave everything alone.
  task automatic run_stack_op(input stack_op_t item, output stack_result_t res);
    logic [4:0] slot;
    res.pop_value = '0;
    res.status    = ST_OK;
    slot          = NIL_SLOT;
    if (item.op == FUNC_POP) begin
      if (item.sid >= NUM_STACKS) begin
        res.status = ST_EMPTY;
      end else if (top_slot[item.sid] == NIL_SLOT) begin
        res.status = ST_EMPTY;
      end else begin
        slot                = top_slot[item.sid];
        res.pop_value       = pool_value[slot];
        top_slot[item.sid]  = pool_link[slot];
        pool_link[slot]     = free_head;
        free_head           = slot;
      end
    end else begin
      // Recycled entries come first, then never-used ones
      if (item.sid >= NUM_STACKS) begin
        res.status = ST_FULL;
      end else if (free_head != NIL_SLOT) begin
        slot      = free_head;
        free_head = pool_link[slot];
      end else if (fresh_count < POOL_DEPTH) begin
        slot        = fresh_count;
        fresh_count = fresh_count + 5'd1;
      end else begin
        res.status = ST_FULL;
      end
      if (res.status == ST_OK) begin
        pool_value[slot]   = item.value;
        pool_link[slot]    = top_slot[item.sid];
        top_slot[item.sid] = slot;
      end
    end
  endtask

  task automatic add_op(input logic op, input logic [1:0] sid, input logic [31:0] value);
    stack_op_t item;
    item.op    = op;
    item.sid   = sid;
    item.value = value;
    op_queue.push_back(item);
    ops_queued++;
  endtask

  // Random operations in bursts that lean toward pushes, pops or neither,
  // so the pool runs full and the stacks run dry again and again.
  task automatic add_random_ops(input int count);
    int          n;
    int          burst_len;
    int          push_pct;
    logic        op;
    logic [1:0]  sid;
    logic [31:0] value;
    n = 0;
    while (n < count) begin
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      burst_len = $urandom_range(8, 40);
      for (int i = 0; i < burst_len && n < count; i++) begin
        op  = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        sid = ($urandom_range(19) == 0) ? BAD_SID : 2'($urandom_range(NUM_STACKS - 1));
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: value = 32'h0000_0000;
            1: value = 32'h7fff_ffff;
            2: value = 32'h8000_0000;
            default: value = 32'hffff_ffff;
          endcase
        end else begin
          value = $urandom;
        end
        add_op(op, sid, value);
        n++;
      end
    end
  endtask

  // Driver: new item or idle at the falling edge; an offered item stays put until taken
  always @(negedge clk) begin : driver
    stack_op_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item = op_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= item.value;
        s_tuser  <= {item.sid, item.op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin : monitor
    stack_op_t     item;
    stack_result_t res;
    stack_result_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        item.op    = s_tuser[0];
        item.sid   = s_tuser[SID_W:1];
        item.value = s_tdata;
        run_stack_op(item, res);
        expected_results.push_back(res);
        ops_accepted++;
        item_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: pop_value %h status %0d", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.pop_value) begin
            $error("pop_value: expected %h, got %h", want.pop_value, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  // Waits at falling edges (counters settle at rising ones) until all is answered
  task automatic drain();
    @(negedge clk);
    while (ops_accepted != ops_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles a little, receiver a lot
    @(posedge clk);
    send_idle_pct = 26;
    recv_idle_pct = 86;

    // Pops from empty stacks, bad stack id on both operations
    for (int s = 0; s < NUM_STACKS; s++) add_op(FUNC_POP, 2'(s), 32'h0);
    add_op(FUNC_POP, BAD_SID, 32'h0);
    add_op(FUNC_PUSH, BAD_SID, 32'h1234_5678);
    // Fill the whole pool from fresh entries, field extremes among the values
    add_op(FUNC_PUSH, 2'd0, 32'h7fff_ffff);
    add_op(FUNC_PUSH, 2'd1, 32'h8000_0000);
    add_op(FUNC_PUSH, 2'd2, 32'hffff_ffff);
    add_op(FUNC_PUSH, 2'd2, 32'h0000_0000);
    for (int i = 4; i < POOL_DEPTH; i++) add_op(FUNC_PUSH, 2'(i % NUM_STACKS), $urandom);
    // Pool full, then a bad id while full
    add_op(FUNC_PUSH, 2'd0, 32'haaaa_5555);
    add_op(FUNC_PUSH, BAD_SID, 32'h5555_aaaa);
    // A pop frees an entry onto the free list, a bad-id pop frees none; the next push reuses it
    add_op(FUNC_POP, 2'd2, 32'hffff_ffff);
    add_op(FUNC_POP, BAD_SID, 32'h0);
    add_op(FUNC_PUSH, 2'd1, 32'h0bad_cafe);
    add_random_ops(640);
    // Sender holds off until every result is in
    drain();

    // Phase 2: the other way round
    @(posedge clk);
    send_idle_pct = 86;
    recv_idle_pct = 26;
    add_random_ops(640);
    drain();

    // Phase 3: full rate on both sides
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_ops(645);
    drain();

    // Then wait on to catch any stray result
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
